// ===== rtl/cdbt_pkg.sv =====
// Shared types and constants for the binary/thirds clock divider.
// No dependencies; imported by cdbt_schmitt, clock_divider_binary_triple_core and the testbench.
`default_nettype none

package cdbt_pkg;

  localparam int MV_W       = 15;   // millivolt samples and thresholds
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 8;
  localparam int QUOT_W     = 6;    // count / 3, 0..63
  localparam int REM_W      = 2;    // count % 3, 0..2
  localparam int NUM_TAPS   = 6;
  localparam int S_TDATA_W  = 32;   // 30 bits of samples, padded to bytes
  localparam int M_TDATA_W  = 8;    // 6 taps, padded to a byte

  localparam logic [COUNT_W-1:0] COUNT_LAST = 8'd191;  // count wraps to 0 after this
  localparam logic [COUNT_W-1:0] COUNT_WRAP = 8'd192;
  localparam logic [REM_W-1:0]   REM_LAST   = 2'd2;

  localparam logic signed [MV_W-1:0] LOW_MV_RESET  = 15'sd100;
  localparam logic signed [MV_W-1:0] HIGH_MV_RESET = 15'sd2000;

  typedef logic signed [MV_W-1:0] mv_t;

  // Hysteresis thresholds shared by both edge detectors
  typedef struct packed {
    logic [MV_W-1:0] low_mv;
    logic [MV_W-1:0] high_mv;
  } thr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THIRDS_MODE = 2'd0,
    REG_LOW_MV      = 2'd1,
    REG_HIGH_MV     = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/cdbt_schmitt.sv =====
// Schmitt edge detector with its latch register: fires on a rising crossing.
// Depends on cdbt_pkg for the sample and threshold types.
`default_nettype none

module cdbt_schmitt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         update,  // level is a live beat for this detector
  input  wire cdbt_pkg::mv_t level,
  input  wire cdbt_pkg::thr_t thr,
  output logic              fire
);
  import cdbt_pkg::*;

  logic armed;
  logic armed_next;
  logic at_high;
  logic at_low;

  assign at_high = $signed(level) >= $signed(thr.high_mv);
  assign at_low  = $signed(level) <= $signed(thr.low_mv);

  assign fire = update & ~armed & at_high;

  always_comb begin
    armed_next = armed;
    if (update) begin
      if (armed) armed_next = ~at_low;
      else       armed_next = at_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) armed <= 1'b0;
    else     armed <= armed_next;
  end

endmodule

`default_nettype wire

// ===== rtl/clock_divider_binary_triple_core.sv =====
// Top level of the binary/thirds clock divider: input stage, count update, tap register.
// Depends on cdbt_pkg and cdbt_schmitt.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: clock_mv, reset_mv; tuser: clock_patched
//  m_      | out | m_tvalid/m_tready  | tdata: tap_one .. tap_six
//  cfg_    | in  | cfg_wen            | cfg_index selects register, cfg_wdata value
//
// Cycles: one beat per cycle while m_tready stays high. A beat enters the input register at
//   its accepting edge and moves on to the tap register when both stages next advance, so its
//   taps reach m_tdata through the input register and then the tap register.
// Stalls: both stages advance together whenever the tap register is empty or being
//   taken, so s_tready follows m_tready through one gate; nothing is lost or repeated.
// Reset: synchronous, clears both valid flags, both detector latches and the count;
//   registers go to their documented reset values. No clearing pass is needed.
`default_nettype none

module clock_divider_binary_triple_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [cdbt_pkg::S_TDATA_W-1:0]  s_tdata,   // [14:0] clock_mv, [29:15] reset_mv
  input  wire logic                            s_tuser,   // [0] clock_patched
  // master stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [cdbt_pkg::M_TDATA_W-1:0]       m_tdata,   // [0] tap_one .. [5] tap_six
  // configuration writes
  input  wire logic                            cfg_wen,
  input  wire logic [cdbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cdbt_pkg::MV_W-1:0]       cfg_wdata
);
  import cdbt_pkg::*;

  // configuration
  logic thirds_mode;
  thr_t thr;

  // input stage
  logic in_valid;
  mv_t  clock_mv;
  mv_t  reset_mv;
  logic clock_patched;

  // count state: edge_count plus its split into count / 3 and count % 3
  logic [COUNT_W-1:0] edge_count, edge_count_next;
  logic [QUOT_W-1:0]  div3_quot, div3_quot_next;
  logic [REM_W-1:0]   div3_rem, div3_rem_next;

  // output stage
  logic                out_valid;
  logic [NUM_TAPS-1:0] taps, taps_next;

  logic adv;
  logic reset_fire;
  logic clock_fire;

  // Both stages move whenever the tap register can take a new value
  assign adv      = ~out_valid | m_tready;
  assign s_tready = adv;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-NUM_TAPS){1'b0}}, taps};

  // Register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thirds_mode <= 1'b0;
      thr.low_mv  <= LOW_MV_RESET;
      thr.high_mv <= HIGH_MV_RESET;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_THIRDS_MODE: thirds_mode <= cfg_wdata[0];
        REG_LOW_MV:      thr.low_mv  <= cfg_wdata;
        REG_HIGH_MV:     thr.high_mv <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: hold the beat until the next stage takes it
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (adv) in_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clock_mv      <= s_tdata[MV_W-1:0];
      reset_mv      <= s_tdata[2*MV_W-1:MV_W];
      clock_patched <= s_tuser;
    end
  end

  // Detectors only see a beat when it moves into the tap register
  cdbt_schmitt u_reset_det (
    .clk    (clk),
    .rst    (rst),
    .update (adv & in_valid),
    .level  (reset_mv),
    .thr    (thr),
    .fire   (reset_fire)
  );

  // A disconnected clock freezes its latch and stops the count advancing
  cdbt_schmitt u_clock_det (
    .clk    (clk),
    .rst    (rst),
    .update (adv & in_valid & clock_patched),
    .level  (clock_mv),
    .thr    (thr),
    .fire   (clock_fire)
  );

  // Clear on a reset edge first, then advance on a clock edge, wrapping after 191.
  // The quotient/remainder pair lets the thirds taps read plain bits.
  always_comb begin
    edge_count_next = reset_fire ? '0 : edge_count;
    div3_quot_next  = reset_fire ? '0 : div3_quot;
    div3_rem_next   = reset_fire ? '0 : div3_rem;
    if (clock_fire) begin
      if (edge_count_next == COUNT_LAST) edge_count_next = '0;
      else                               edge_count_next = edge_count_next + 1'b1;
      if (div3_rem_next == REM_LAST) begin
        div3_rem_next  = '0;
        div3_quot_next = div3_quot_next + 1'b1;  // 63 -> 0 together with the count wrap
      end else begin
        div3_rem_next  = div3_rem_next + 1'b1;
      end
    end
  end

  // Divide by 2^(i+1): high while bit i of the count is low.
  // Divide by 3: high while count % 3 < 2.
  // Divide by 3*2^k, k >= 1: high while bit k-1 of count / 3 is low.
  always_comb begin
    if (thirds_mode) begin
      taps_next[0] = (div3_rem_next != REM_LAST);
      for (int i = 1; i < NUM_TAPS; i++) taps_next[i] = ~div3_quot_next[i-1];
    end else begin
      for (int i = 0; i < NUM_TAPS; i++) taps_next[i] = ~edge_count_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      div3_quot  <= '0;
      div3_rem   <= '0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        edge_count <= edge_count_next;
        div3_quot  <= div3_quot_next;
        div3_rem   <= div3_rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) taps <= taps_next;
  end

  // Count stays inside its wrap range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    edge_count < COUNT_WRAP)
    else $error("edge_count out of range");

  // Quotient and remainder track the count exactly
  a_div3_match: assert property (@(posedge clk) disable iff (rst)
    (COUNT_W'(div3_quot) * COUNT_W'(3) + COUNT_W'(div3_rem)) == edge_count)
    else $error("count / 3 split out of step with edge_count");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div3_rem != 2'd3)
    else $error("count mod 3 out of range");

  // Count only moves when a beat passes into the tap register
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv && in_valid) |=> $stable(edge_count))
    else $error("edge_count changed without a beat");

  // A beat in the input stage always yields a result on the next edge it moves
  a_beat_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && in_valid) |=> out_valid)
    else $error("beat lost between stages");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for clock_divider_binary_triple_core: streams sample ticks,
// predicts the six divider taps in a local model and checks every output beat.
// Depends on cdbt_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module testbench;
  import cdbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int PIPE_SETTLE    = 6;     // two pipeline stages plus margin
  localparam int MAX_REPORTS    = 10;
  localparam int MV_MIN         = -16384;
  localparam int MV_MAX         = 16383;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b1;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [MV_W-1:0]        cfg_wdata = '0;

  // Local copy of the divider: registers, detector latches and the edge count
  logic                   thirds      = 1'b0;
  mv_t                    low_mv      = LOW_MV_RESET;
  mv_t                    high_mv     = HIGH_MV_RESET;
  logic                   clk_latched = 1'b0;
  logic                   rst_latched = 1'b0;
  logic [COUNT_W-1:0]     edge_cnt    = '0;

  logic [NUM_TAPS-1:0]    pending_taps[$];   // predicted taps, newest first
  logic [NUM_TAPS-1:0]    want_taps;
  logic                   tap_bad;
  int                     error_count  = 0;
  int                     idle_pct     = 0;  // chance of an idle burst, both sides
  int                     stall_left   = 0;
  int                     quiet_cycles = 0;

  clock_divider_binary_triple_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [14:0] clock_mv, [29:15] reset_mv, [31:30] zero
    .s_tuser   (s_tuser),    // [0] clock_patched
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [0] tap_one .. [5] tap_six, [7:6] zero
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the local divider by one tick and return the taps it shows afterwards.
  // The reset detector acts first, so a reset and a clock edge together leave a count of 1.
  function automatic logic [NUM_TAPS-1:0] advance_divider(input mv_t clock_mv,
                                                          input mv_t reset_mv,
                                                          input logic patched);
    logic [NUM_TAPS-1:0] taps;
    int n;
    if (rst_latched) begin
      // release at or below the low threshold, equality included
      if (reset_mv <= low_mv) rst_latched = 1'b0;
    end else if (reset_mv >= high_mv) begin
      rst_latched = 1'b1;
      edge_cnt    = '0;
    end
    // a disconnected clock leaves its detector untouched
    if (patched) begin
      if (clk_latched) begin
        if (clock_mv <= low_mv) clk_latched = 1'b0;
      end else if (clock_mv >= high_mv) begin
        clk_latched = 1'b1;
        edge_cnt    = (edge_cnt == COUNT_LAST) ? '0 : edge_cnt + 1'b1;
      end
    end
    for (int i = 0; i < NUM_TAPS; i++) begin
      n       = (thirds ? 3 : 2) << i;
      taps[i] = (int'(edge_cnt) % n) < (n + 1) / 2;
    end
    return taps;
  endfunction

  function automatic mv_t level_between(input int lo, input int hi);
    return mv_t'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // Send one tick: optionally idle first, then hold the beat until s_tready was seen.
  // Valid stays high between back-to-back beats so it is never dropped and raised in one step.
  task automatic send_tick(input mv_t clock_mv, input mv_t reset_mv, input logic patched);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, reset_mv, clock_mv};
    s_tuser  <= patched;
    // sample ready mid-cycle, where nothing moves; the beat goes at the next rising edge
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    pending_taps.push_front(advance_divider(clock_mv, reset_mv, patched));
  endtask

  // Drop valid and wait for every predicted beat, then let the pipeline go quiet
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [MV_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_THIRDS_MODE: thirds  = value[0];
      REG_LOW_MV:      low_mv  = mv_t'(value);
      REG_HIGH_MV:     high_mv = mv_t'(value);
      default: begin
        // unknown index: the block ignores it
      end
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_divider(input logic mode, input int low, input int high);
    drain_pipeline();
    write_reg(REG_THIRDS_MODE, {{(MV_W-1){1'b0}}, mode});
    write_reg(REG_LOW_MV, mv_t'(low));
    write_reg(REG_HIGH_MV, mv_t'(high));
  endtask

  // Random pulse trains: mostly clean clock edges around the current thresholds,
  // a few rail-to-rail noise samples, rare reset pulses and the odd unpatched tick.
  task automatic run_pulse_train(input int ticks, input int reset_per_mille,
                                 input int noise_pct);
    mv_t  clock_mv;
    mv_t  reset_mv;
    logic clock_up;
    int   lo;
    int   hi;
    int   quiet_top;
    lo        = int'(low_mv);
    hi        = int'(high_mv);
    // a quiet reset level must neither fire nor stay latched, even with inverted thresholds
    quiet_top = (lo < hi - 1) ? lo : hi - 1;
    clock_up  = 1'b0;
    repeat (ticks) begin
      if ($urandom_range(99, 0) < 92) clock_up = !clock_up;
      if ($urandom_range(99, 0) < noise_pct) clock_mv = mv_t'($urandom);
      else if (clock_up) clock_mv = level_between(hi, MV_MAX);
      else clock_mv = level_between(MV_MIN, lo);
      if ($urandom_range(999, 0) < reset_per_mille) begin
        reset_mv = $urandom_range(1, 0) ? mv_t'($urandom) : level_between(hi, MV_MAX);
      end else begin
        reset_mv = level_between(MV_MIN, quiet_top);
      end
      send_tick(clock_mv, reset_mv, $urandom_range(99, 0) < 93);
    end
  endtask

  // Default thresholds: firing and release at equality, rails, unpatched clock,
  // reset and clock edge together, reset while the clock is unpatched
  task automatic test_levels_and_edges();
    send_tick(mv_t'(1999),   mv_t'(0),      1'b1);  // just under the high threshold
    send_tick(mv_t'(2000),   mv_t'(0),      1'b1);  // fires at equality
    send_tick(mv_t'(101),    mv_t'(0),      1'b1);  // still latched
    send_tick(mv_t'(100),    mv_t'(0),      1'b1);  // releases at equality
    send_tick(mv_t'(MV_MAX), mv_t'(MV_MIN), 1'b1);
    send_tick(mv_t'(MV_MIN), mv_t'(MV_MIN), 1'b1);
    send_tick(mv_t'(MV_MAX), mv_t'(0),      1'b0);  // frozen: no edge, no latch
    send_tick(mv_t'(MV_MIN), mv_t'(0),      1'b0);
    send_tick(mv_t'(MV_MAX), mv_t'(MV_MAX), 1'b1);  // reset then clock on one tick
    send_tick(mv_t'(MV_MIN), mv_t'(MV_MIN), 1'b1);
    send_tick(mv_t'(5000),   mv_t'(-1),     1'b1);
    send_tick(mv_t'(3000),   mv_t'(3000),   1'b0);  // reset still clears when unpatched
  endtask

  // Thirds mode with inverted thresholds, then with the widest legal window
  task automatic test_thirds_and_inverted();
    drain_pipeline();
    write_reg(REG_UNUSED, mv_t'($urandom));
    set_divider(1'b1, 12000, -12000);
    send_tick(mv_t'(0),      mv_t'(-13000), 1'b1);  // fires: 0 >= high
    send_tick(mv_t'(0),      mv_t'(-13000), 1'b1);  // releases: 0 <= low
    send_tick(mv_t'(0),      mv_t'(0),      1'b1);  // reset and clock together
    send_tick(mv_t'(0),      mv_t'(0),      1'b1);
    send_tick(mv_t'(12000),  mv_t'(-13000), 1'b1);
    set_divider(1'b1, -12000, 12000);
    send_tick(mv_t'(12000),  mv_t'(-12000), 1'b1);  // fires at the top of the window
    send_tick(mv_t'(-11999), mv_t'(-12000), 1'b1);  // not yet released
    send_tick(mv_t'(-12000), mv_t'(-12000), 1'b1);
    send_tick(mv_t'(12000),  mv_t'(-12000), 1'b1);
    send_tick(mv_t'(-12000), mv_t'(-12000), 1'b1);
  endtask

  // Long binary run with no reset pulses so the count wraps past 191
  task automatic test_count_wrap();
    set_divider(1'b0, int'(LOW_MV_RESET), int'(HIGH_MV_RESET));
    idle_pct = 25;
    run_pulse_train(600, 0, 5);
  endtask

  task automatic test_thirds_random();
    int low;
    low = $urandom_range(20000, 0) - 12000;
    set_divider(1'b1, low, low + int'($urandom_range(12000 - low, 1)));
    idle_pct = 40;
    run_pulse_train(250, 12, 10);
  endtask

  task automatic test_inverted_random();
    int high;
    high = $urandom_range(20000, 0) - 12000;
    set_divider(1'b0, high + int'($urandom_range(12000 - high, 0)), high);
    idle_pct = 15;
    run_pulse_train(250, 12, 10);
  endtask

  // Widest window and no idling on either side for the closing stretch
  task automatic test_full_rate();
    set_divider(1'b1, -12000, 12000);
    idle_pct = 0;
    run_pulse_train(250, 8, 10);
  endtask

  // Receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 2) begin
      stall_left <= $urandom_range(6, 0);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // Check each output beat mid-cycle, against the oldest prediction
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_taps.size() == 0) begin
        flag_error($sformatf("tap beat %b with nothing predicted", m_tdata[NUM_TAPS-1:0]));
      end else begin
        want_taps = pending_taps.pop_back();
        tap_bad   = 1'b0;
        for (int i = 0; i < NUM_TAPS; i++) begin
          if (m_tdata[i] !== want_taps[i]) tap_bad = 1'b1;
        end
        if (tap_bad) begin
          flag_error($sformatf("taps six..one expected %b, got %b",
                               want_taps, m_tdata[NUM_TAPS-1:0]));
        end
      end
    end
  end

  // Watchdog: abandon the run if neither side moves a beat for too long
  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_levels_and_edges();
    test_thirds_and_inverted();
    test_count_wrap();
    test_thirds_random();
    test_inverted_random();
    test_full_rate();
    drain_pipeline();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cdbt_pkg.sv
rtl/cdbt_schmitt.sv
rtl/clock_divider_binary_triple_core.sv
tb/testbench.sv
